FILE: rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg: shared definitions for the caseless substring search
// Sizes, register indexes, the cell control bundle and ASCII case folding.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int OFFSET_WIDTH = 16;

  // Pattern bytes that the two pattern registers carry
  localparam int PATTERN_REG_BYTES = 16;

  localparam int CFG_WIDTH = 64;
  localparam int CFG_IDX_W = 2;
  localparam int PLEN_W    = 5;

  // Effective length 1..PATTERN_MAX and pattern byte select
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int SEL_W = $clog2(PATTERN_MAX);

  // Byte counter saturates at OFFSET_MAX + PATTERN_MAX
  localparam int CNT_W = OFFSET_WIDTH + 1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX =
    CNT_W'((64'd1 << OFFSET_WIDTH) - 64'd1 + 64'(PATTERN_MAX));

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic shift;  // a byte transfers in: advance the window
    logic clear;  // final byte of the buffer: drop the window
  } css_ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: rtl/css_cell.sv
// ----------------------------------------------------------------------------
// css_cell: one stage of the byte window
// Holds one folded byte and its fill flag, passes them to the next stage on
// every transfer and compares its byte against the pattern byte for its place.
// ----------------------------------------------------------------------------
module css_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  css_pkg::css_ctl_t ctl,
  input  logic [7:0]        byte_in,
  input  logic              valid_in,
  input  logic [7:0]        exp_byte,
  input  logic              active,
  output logic [7:0]        byte_out,
  output logic              valid_out,
  output logic              hit
);

  logic [7:0] byte_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;

  // Places past the pattern length always agree
  assign hit = !active || (valid_r && (byte_r == exp_byte));

endmodule

FILE: rtl/caseless_substring_search.sv
// ----------------------------------------------------------------------------
// caseless_substring_search: first case-insensitive pattern match in a buffer
// Scans bytes through a chain of window cells, one per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Configure pattern_low, pattern_high and pattern_length through the cfg_
//   write port while no buffer is in flight. Feed the buffer one byte per
//   transfer on the in_ channel, with in_last_byte on the final byte.
//   The out_ channel carries at most one result per buffer: found set with
//   the start offset of the first match (saturating at 65535), or found
//   clear at the final byte when the buffer held no match.
//   Throughput is one byte per clock while in_stall is low; the window lives
//   in a row of cells that shift every transfer, so all pattern places
//   compare in parallel. A result appears in the output register on the
//   clock after the byte that completes the match or ends the buffer.
//   When the receiver stalls with a result waiting, in_stall rises and the
//   next byte is held off until the result transfers.
//   Reset clears the window, the byte count, the match flag and the output;
//   the pattern resets to a single zero byte. The buffer state also clears
//   after every final byte.
// ----------------------------------------------------------------------------
module caseless_substring_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [css_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [css_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [css_pkg::OFFSET_WIDTH-1:0]  out_match_offset
);

  localparam int NC    = css_pkg::PATTERN_MAX - 1;
  localparam int PM    = css_pkg::PATTERN_MAX;
  localparam int LEN_W = css_pkg::LEN_W;
  localparam int SEL_W = css_pkg::SEL_W;
  localparam int CNT_W = css_pkg::CNT_W;
  localparam int OFF_W = css_pkg::OFFSET_WIDTH;

  // Configuration registers
  logic [css_pkg::CFG_WIDTH-1:0] pattern_low_r;
  logic [css_pkg::CFG_WIDTH-1:0] pattern_high_r;
  logic [css_pkg::PLEN_W-1:0]    pattern_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= css_pkg::PLEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        css_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        css_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        css_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[css_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length and folded pattern bytes
  logic [LEN_W-1:0] len_eff;
  logic [7:0]       pat_fold [PM];
  logic [2*css_pkg::CFG_WIDTH-1:0] pat_all;

  assign pat_all = {pattern_high_r, pattern_low_r};

  always_comb begin
    if (pattern_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(pattern_length_r) > PM) begin
      len_eff = LEN_W'(PM);
    end else begin
      len_eff = LEN_W'(pattern_length_r);
    end
  end

  always_comb begin
    for (int i = 0; i < PM; i++) begin
      if (i < css_pkg::PATTERN_REG_BYTES) begin
        pat_fold[i] = css_pkg::fold_case(
          pat_all[8*(i % css_pkg::PATTERN_REG_BYTES) +: 8]);
      end else begin
        pat_fold[i] = 8'h00;
      end
    end
  end

  // Handshake
  logic in_xfer;
  logic out_valid_r;
  logic out_found_r;
  logic [OFF_W-1:0] out_offset_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  css_pkg::css_ctl_t cell_ctl;
  assign cell_ctl.shift = in_xfer;
  assign cell_ctl.clear = in_xfer && in_last_byte;

  // Window cells: cell k holds the byte k places back
  logic [7:0]    win_byte  [NC+1];
  logic          win_valid [NC+1];
  logic [NC-1:0] cell_hit;
  logic [7:0]    cur_fold;
  logic          cur_hit;

  assign cur_fold     = css_pkg::fold_case(in_data_byte);
  assign win_byte[0]  = cur_fold;
  assign win_valid[0] = 1'b1;
  assign cur_hit = (cur_fold == pat_fold[SEL_W'(len_eff - LEN_W'(1))]);

  for (genvar k = 1; k <= NC; k++) begin : g_cell
    logic             active;
    logic [SEL_W-1:0] sel;

    assign active = (len_eff > LEN_W'(k));
    assign sel    = active ? SEL_W'(len_eff - LEN_W'(1) - LEN_W'(k)) : '0;

    css_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .byte_in   (win_byte[k-1]),
      .valid_in  (win_valid[k-1]),
      .exp_byte  (pat_fold[sel]),
      .active    (active),
      .byte_out  (win_byte[k]),
      .valid_out (win_valid[k]),
      .hit       (cell_hit[k-1])
    );
  end

  // Byte count and match flag
  logic [CNT_W-1:0] bytes_seen_r;
  logic [CNT_W-1:0] bytes_seen_nxt;
  logic             match_seen_r;
  logic             match_seen_nxt;
  logic             hit_now;
  logic             res_fire;
  logic [CNT_W:0]   total;
  logic [CNT_W:0]   off_full;
  logic [OFF_W-1:0] off_sat;

  assign hit_now  = !match_seen_r && cur_hit && (&cell_hit);
  assign res_fire = in_xfer && (hit_now || (in_last_byte && !match_seen_r));

  assign total    = {1'b0, bytes_seen_r} + (CNT_W+1)'(1);
  assign off_full = total - (CNT_W+1)'(len_eff);
  assign off_sat  = (off_full > (CNT_W+1)'(css_pkg::OFFSET_MAX)) ?
                    css_pkg::OFFSET_MAX : off_full[OFF_W-1:0];

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    match_seen_nxt = match_seen_r;
    if (in_xfer) begin
      if (in_last_byte) begin
        bytes_seen_nxt = '0;
        match_seen_nxt = 1'b0;
      end else begin
        if (bytes_seen_r < css_pkg::COUNT_MAX) begin
          bytes_seen_nxt = bytes_seen_r + CNT_W'(1);
        end
        if (hit_now) begin
          match_seen_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      match_seen_r <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      match_seen_r <= match_seen_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_found_r  <= hit_now;
      out_offset_r <= hit_now ? off_sat : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  // Checks
  a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(in_valid && !in_stall))
    else $error("result appeared without a byte transfer");

  a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_offset_r == '0))
    else $error("no-match result carries a nonzero offset");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_byte) |=> (bytes_seen_r == '0 && !match_seen_r))
    else $error("buffer state not cleared after final byte");

  a_single_found: assert property (@(posedge clk) disable iff (!rst_n)
    (match_seen_r && in_xfer) |=> !(out_valid_r && out_found_r && $past(res_fire)))
    else $error("second match reported in one buffer");

endmodule

FILE: tb/sv/tb_caseless_substring_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_caseless_substring_search: self-checking bench for the substring search
// Streams byte buffers into the block, mirrors the window, byte count and
// match flag in a local predictor, and compares every result transfer with
// the oldest predicted one. Directed buffers cover case folding, pattern
// length limits, first-match-only and offsets wider than one byte; random
// buffers with embedded patterns run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_caseless_substring_search;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_MAX   = 10;
  localparam int WINDOW_DEPTH = css_pkg::PATTERN_MAX - 1;
  localparam int PHASE_ITEMS  = 500;
  localparam int LONG_LEAD    = 300;

  typedef struct packed {
    logic                             found;
    logic [css_pkg::OFFSET_WIDTH-1:0] offset;
  } search_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [css_pkg::CFG_IDX_W-1:0]    cfg_index = css_pkg::REG_PATTERN_LOW;
  logic [css_pkg::CFG_WIDTH-1:0]    cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_data_byte = 8'h00;
  logic                             in_last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_found;
  logic [css_pkg::OFFSET_WIDTH-1:0] out_match_offset;

  // Mirror of the block's pattern registers and per-buffer search state
  logic [63:0]    pat_lo_reg = '0;
  logic [63:0]    pat_hi_reg = '0;
  logic [4:0]     pat_len_reg = 5'd1;
  logic [7:0]     recent_bytes [WINDOW_DEPTH];
  int unsigned    bytes_taken = 0;
  bit             hit_reported = 1'b0;

  search_result_t expected_results [$];
  int             error_count = 0;
  int             items_sent = 0;
  int             sender_idle_pct = 0;
  int             receiver_stall_pct = 0;
  int unsigned    cycle_count = 0;

  caseless_substring_search u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= css_pkg::CHAR_UPPER_A && c <= css_pkg::CHAR_UPPER_Z) begin
      return c + css_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = lower_ascii(c);
    if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) begin
      return c ^ css_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(input int i);
    if (i < 8) begin
      return pat_lo_reg[8*i +: 8];
    end
    if (i < css_pkg::PATTERN_REG_BYTES) begin
      return pat_hi_reg[8*(i-8) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic int active_length();
    if (pat_len_reg == 0) begin
      return 1;
    end
    if (pat_len_reg > css_pkg::PATTERN_MAX) begin
      return css_pkg::PATTERN_MAX;
    end
    return int'(pat_len_reg);
  endfunction

  function automatic void clear_search_state();
    int k;
    for (k = 0; k < WINDOW_DEPTH; k++) begin
      recent_bytes[k] = 8'h00;
    end
    bytes_taken  = 0;
    hit_reported = 1'b0;
  endfunction

  // Advance the mirrored search by one byte and queue any result it causes
  function automatic void predict_search(input logic [7:0] b, input logic last);
    int             n;
    int             k;
    int unsigned    start;
    bit             hit;
    search_result_t r;
    n = active_length();
    if (!hit_reported && bytes_taken + 1 >= n) begin
      hit = (lower_ascii(b) == lower_ascii(pattern_at(n - 1)));
      for (k = 1; k < n; k++) begin
        if (lower_ascii(recent_bytes[k-1]) != lower_ascii(pattern_at(n - 1 - k))) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        start    = bytes_taken + 1 - n;
        r.found  = 1'b1;
        r.offset = css_pkg::OFFSET_MAX;
        if (start < css_pkg::OFFSET_MAX) begin
          r.offset = start[css_pkg::OFFSET_WIDTH-1:0];
        end
        expected_results.push_back(r);
        hit_reported = 1'b1;
      end
    end
    for (k = WINDOW_DEPTH - 1; k > 0; k--) begin
      recent_bytes[k] = recent_bytes[k-1];
    end
    recent_bytes[0] = b;
    if (bytes_taken < css_pkg::COUNT_MAX) begin
      bytes_taken++;
    end
    if (last) begin
      if (!hit_reported) begin
        r.found  = 1'b0;
        r.offset = '0;
        expected_results.push_back(r);
      end
      clear_search_state();
    end
  endfunction

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("unexpected result: found=%0b offset=%0d", out_found, out_match_offset);
        end
      end else begin
        want = expected_results.pop_front();
        if (want.found !== out_found || want.offset !== out_match_offset) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("result mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                     want.found, want.offset, out_found, out_match_offset);
          end
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the byte transfers
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_search(b, last);
    items_sent++;
  endtask

  // First character of the string goes out first
  task automatic send_text(input logic [127:0] text, input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_byte(text[8*(count-1-i) +: 8], i == count - 1);
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len);
    wait_until_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= css_pkg::REG_PATTERN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= css_pkg::REG_PATTERN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= css_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= css_pkg::CFG_WIDTH'(len);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pat_lo_reg  = lo;
    pat_hi_reg  = hi;
    pat_len_reg = len;
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    logic [7:0] edges [6] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF};
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return edges[$urandom_range(0, 5)];
      3: return 8'($urandom_range(8'h41, 8'h44));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_pattern();
    // reset pattern is a single zero byte
    send_text(16'h4100, 2);
  endtask

  task automatic test_case_folding();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    load_pattern(64'h7B40_7A41, 64'h0, 5'd4);
    send_text("aZ@{", 4);
    // '@' and '`' differ by the case bit but are not letters
    send_text("aZ`[", 4);
  endtask

  task automatic test_length_limits();
    logic [63:0] lo;
    logic [63:0] hi;
    int          i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_pattern_byte();
      hi[8*i +: 8] = pick_pattern_byte();
    end
    hi[15:8] = 8'h00;
    // length above the maximum acts as a full-length pattern, match on last byte
    load_pattern(lo, hi, 5'd17);
    for (i = 0; i < css_pkg::PATTERN_MAX; i++) begin
      send_byte(vary_case(pattern_at(i)), i == css_pkg::PATTERN_MAX - 1);
    end
    // length zero acts as one
    load_pattern(64'h71, 64'h0, 5'd0);
    send_text("Q", 1);
  endtask

  task automatic test_first_match_only();
    load_pattern(64'h6261, 64'h0, 5'd2);
    send_text("xaBAb", 5);
    // buffer shorter than the pattern
    send_text("A", 1);
  endtask

  // Match starting past offset 255 so the upper offset bits are exercised
  task automatic test_long_buffer();
    int i;
    load_pattern(64'h5372_516B, 64'h0, 5'd4);
    for (i = 0; i < LONG_LEAD; i++) begin
      send_byte(8'($urandom_range(0, 8'h3F)), 1'b0);
    end
    for (i = 0; i < 4; i++) begin
      send_byte(vary_case(pattern_at(i)), 1'b0);
    end
    send_byte(8'($urandom_range(0, 8'h3F)), 1'b1);
  endtask

  task automatic random_config();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    int          i;
    case ($urandom_range(0, 9))
      0: len = 5'd1;
      1: len = 5'd16;
      2: len = 5'd0;
      3: len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(2, 15));
    endcase
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_pattern_byte();
      hi[8*i +: 8] = pick_pattern_byte();
    end
    case ($urandom_range(0, 9))
      0: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      1: begin
        lo = '1;
        hi = '1;
      end
      2: begin
        lo = '0;
        hi = '0;
      end
      default: ;
    endcase
    load_pattern(lo, hi, len);
  endtask

  // Mostly buffers that carry the pattern in random case; the rest are near
  // misses built from pattern bytes, or plain noise
  task automatic random_buffer();
    int         n;
    int         blen;
    int         mode;
    int         at;
    int         i;
    logic [7:0] b;
    n = active_length();
    case ($urandom_range(0, 9))
      0: blen = $urandom_range(1, n);
      1: blen = $urandom_range(40, 120);
      default: blen = $urandom_range(n, n + 16);
    endcase
    mode = $urandom_range(0, 9);
    at   = -1;
    if (mode < 7 && blen >= n) begin
      at = $urandom_range(0, blen - n);
    end
    for (i = 0; i < blen; i++) begin
      if (at >= 0 && i >= at && i < at + n) begin
        b = vary_case(pattern_at(i - at));
      end else if (mode < 9 && $urandom_range(0, 1) == 1) begin
        b = vary_case(pattern_at($urandom_range(0, n - 1)));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b, i == blen - 1);
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    int goal;
    int chunk_end;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      random_config();
      chunk_end = items_sent + $urandom_range(60, 140);
      while (items_sent < chunk_end && items_sent < goal) begin
        random_buffer();
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0);
    random_phase(78, 0);
    random_phase(0, 78);
    random_phase(20, 20);
  endtask

  initial begin
    clear_search_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_pattern();
    test_case_folding();
    test_length_limits();
    test_first_match_only();
    test_long_buffer();
    test_random_traffic();
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/css_pkg.sv
rtl/css_cell.sv
rtl/caseless_substring_search.sv
tb/sv/tb_caseless_substring_search.sv
